FILE: sv/bcdt_pkg.sv
// ----------------------------------------------------------------------------
// bcdt_pkg
// Shared types, codes and helpers of the BCD countdown timer.
// ----------------------------------------------------------------------------
`default_nettype none

package bcdt_pkg;

  // Request codes
  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_START  = 2'd2,
    REQ_FINISH = 2'd3
  } req_e;

  // Stop level codes that matter; the others hold
  localparam logic [1:0] STOP_RUN   = 2'd0;
  localparam logic [1:0] STOP_SLEEP = 2'd2;

  // Phase codes
  localparam logic [1:0] PH_WAIT    = 2'd0;
  localparam logic [1:0] PH_COUNT   = 2'd1;
  localparam logic [1:0] PH_GRACE   = 2'd2;
  localparam logic [1:0] PH_EXPIRED = 2'd3;

  // Register indexes
  localparam logic REG_TICKS_PER_SECOND = 1'b0;
  localparam logic REG_GRACE_TICKS      = 1'b1;

  // Reset values
  localparam logic [7:0] TICKS_PER_SECOND_RST = 8'd60;
  localparam logic [7:0] GRACE_TICKS_RST      = 8'd30;
  localparam logic [7:0] PRESCALER_RST        = 8'd60;

  // One result item
  typedef struct packed {
    logic [7:0] seconds_bcd;
    logic       timed_out;
    logic       running;
    logic [1:0] phase;
    logic [7:0] tick_count;
  } res_t;

  // Two-digit BCD decrement; 00 wraps to 99, non-BCD digits just count down
  function automatic logic [7:0] bcd_dec(input logic [7:0] v);
    logic [3:0] lo;
    logic [3:0] hi;
    lo = v[3:0];
    hi = v[7:4];
    if (lo == 4'd0) begin
      lo = 4'd9;
      hi = (hi == 4'd0) ? 4'd9 : hi - 4'd1;
    end else begin
      lo = lo - 4'd1;
    end
    return {hi, lo};
  endfunction

endpackage

`default_nettype wire

FILE: sv/bcdt_if.sv
// ----------------------------------------------------------------------------
// bcdt interfaces
// Request, result and register write channels of the BCD countdown timer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcdt_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       mode_blocked;
  logic       debug_hold;
  logic       break_hold;
  logic [1:0] stop_level;
  logic [7:0] load_value;

  modport source (output valid, req_type, mode_blocked, debug_hold, break_hold,
                  stop_level, load_value, input ready);
  modport sink   (input valid, req_type, mode_blocked, debug_hold, break_hold,
                  stop_level, load_value, output ready);
endinterface

interface bcdt_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] seconds_bcd;
  logic       timed_out;
  logic       running;
  logic [1:0] phase;
  logic [7:0] tick_count;

  modport source (output valid, seconds_bcd, timed_out, running, phase, tick_count,
                  input ready);
  modport sink   (input valid, seconds_bcd, timed_out, running, phase, tick_count,
                  output ready);
endinterface

interface bcdt_cfg_if;
  logic       valid;
  logic       ready;
  logic       reg_index;
  logic [7:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

FILE: sv/bcd_countdown_select_timer.sv
// ----------------------------------------------------------------------------
// bcd_countdown_select_timer
// Frame-tick countdown timer with two-digit BCD seconds. Every request item
// (tick, load, start, finish) updates the timer state in the cycle it is
// transferred and yields one result item with the state after the update.
// The block takes one request per clock while the skid register is empty; each
// result is registered before it appears on the result channel. A result
// register backed by one skid register lets one more request in while the
// consumer stalls; request ready drops only when both hold an untaken result.
// Register writes take effect on the next clock and are accepted at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_countdown_select_timer (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bcdt_cfg_if.sink    cfg_i,
  bcdt_req_if.sink    req_i,
  bcdt_res_if.source  res_o
);
  import bcdt_pkg::*;

  // Configuration registers
  logic [7:0] ticks_per_second_q;
  logic [7:0] grace_ticks_q;

  // Timer state
  logic [1:0] phase_q,     phase_d;
  logic [7:0] prescaler_q, prescaler_d;
  logic [7:0] seconds_q,   seconds_d;
  logic [7:0] grace_q,     grace_d;
  logic       expired_q,   expired_d;
  logic       run_q,       run_d;

  // Result buffering
  res_t       out_q, skid_q, res_new;
  logic       out_valid_q, skid_valid_q;
  logic       req_xfer, res_xfer;
  logic       held;
  logic [7:0] pre_dec, grace_dec, sec_dec;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = !skid_valid_q;
  assign req_xfer    = req_i.valid && req_i.ready;
  assign res_xfer    = out_valid_q && res_o.ready;
  assign held        = req_i.mode_blocked || req_i.debug_hold || req_i.break_hold;

  // Capture register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_per_second_q <= TICKS_PER_SECOND_RST;
      grace_ticks_q      <= GRACE_TICKS_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.reg_index)
        REG_TICKS_PER_SECOND: ticks_per_second_q <= cfg_i.wdata;
        REG_GRACE_TICKS:      grace_ticks_q      <= cfg_i.wdata;
        default:              ;
      endcase
    end
  end

  assign pre_dec   = prescaler_q - 8'd1;
  assign grace_dec = grace_q - 8'd1;
  assign sec_dec   = bcd_dec(seconds_q);

  // Next timer state for the request at the input
  always_comb begin
    phase_d     = phase_q;
    prescaler_d = prescaler_q;
    seconds_d   = seconds_q;
    grace_d     = grace_q;
    expired_d   = expired_q;
    run_d       = run_q;
    case (req_e'(req_i.req_type))
      REQ_TICK: begin
        if (!held) begin
          case (phase_q)
            PH_WAIT: begin
              if (req_i.stop_level == STOP_RUN) phase_d = PH_COUNT;
            end
            PH_COUNT: begin
              if (req_i.stop_level == STOP_SLEEP) phase_d = PH_WAIT;
              prescaler_d = pre_dec;
              if (pre_dec == 8'd0) begin
                prescaler_d = ticks_per_second_q;
                seconds_d   = sec_dec;
                if (sec_dec == 8'd0) begin
                  phase_d = PH_GRACE;
                  grace_d = grace_ticks_q;
                end
              end
            end
            PH_GRACE: begin
              if (req_i.stop_level == STOP_SLEEP) phase_d = PH_WAIT;
              if (seconds_q != 8'd0) begin
                phase_d     = PH_COUNT;
                prescaler_d = ticks_per_second_q;
              end else begin
                grace_d = grace_dec;
                if (grace_dec == 8'd0) begin
                  expired_d = 1'b1;
                  phase_d   = PH_EXPIRED;
                end
              end
            end
            default: begin
              if (req_i.stop_level == STOP_SLEEP) phase_d = PH_WAIT;
              expired_d = 1'b1;
              if (seconds_q != 8'd0) begin
                phase_d     = PH_COUNT;
                prescaler_d = ticks_per_second_q;
              end
            end
          endcase
        end
      end
      REQ_LOAD: begin
        seconds_d = req_i.load_value;
      end
      REQ_START: begin
        run_d     = 1'b1;
        phase_d   = PH_WAIT;
        expired_d = 1'b0;
      end
      default: begin
        phase_d = PH_WAIT;
        run_d   = 1'b0;
        grace_d = 8'd0;
      end
    endcase
  end

  assign res_new = '{seconds_bcd: seconds_d, timed_out: expired_d, running: run_d,
                     phase: phase_d, tick_count: prescaler_d};

  // Advance timer state on each request transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      prescaler_q <= PRESCALER_RST;
      seconds_q   <= 8'd0;
      grace_q     <= 8'd0;
      expired_q   <= 1'b0;
      run_q       <= 1'b0;
    end else if (req_xfer) begin
      phase_q     <= phase_d;
      prescaler_q <= prescaler_d;
      seconds_q   <= seconds_d;
      grace_q     <= grace_d;
      expired_q   <= expired_d;
      run_q       <= run_d;
    end
  end

  // Result register and skid valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || res_xfer) begin
        out_valid_q  <= skid_valid_q || req_xfer;
        skid_valid_q <= skid_valid_q && req_xfer;
      end else if (req_xfer) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Result payloads: drain skid first, keep order
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || res_xfer) begin
      out_q <= skid_valid_q ? skid_q : res_new;
      if (req_xfer) skid_q <= res_new;
    end else if (req_xfer) begin
      skid_q <= res_new;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.seconds_bcd = out_q.seconds_bcd;
  assign res_o.timed_out   = out_q.timed_out;
  assign res_o.running     = out_q.running;
  assign res_o.phase       = out_q.phase;
  assign res_o.tick_count  = out_q.tick_count;

  // Skid never holds a result without the result register holding one
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q) else $error("skid valid without output valid");

  // Expired phase is only reached with time over raised
  a_expired_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EXPIRED) |-> expired_q) else $error("expired phase without time over");

  // A stalled result stays presented
  a_out_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> out_valid_q) else $error("stalled result dropped");

  // A request transfer with a stalled full result register fills the skid
  a_skid_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_xfer && out_valid_q && !res_o.ready) |=> skid_valid_q)
    else $error("request lost behind stalled result");

endmodule

`default_nettype wire
